// ===== src/vgu_pkg.sv =====
// ----------------------------------------------------------------------
// Vector geometry unit package
// Widths, operation codes, side-band structs and saturation helpers.
// ----------------------------------------------------------------------
package vgu_pkg;

    localparam int DATA_W    = 32;
    localparam int FRAC_BITS = 16;
    localparam int WGT_W     = 17;
    localparam int LANES     = 3;

    localparam int PROD_W   = 2 * DATA_W;
    localparam int SUM_W    = 2 * DATA_W;
    localparam int DOT_W    = 2 * DATA_W + 2;
    localparam int ROOT_W   = DATA_W;
    localparam int SQ_REM_W = 2 * DATA_W + 2;
    localparam int NUM_W    = 2 * DATA_W + FRAC_BITS;
    localparam int DEN_W    = 2 * DATA_W;
    localparam int QBITS    = DATA_W + 1;
    localparam int CMP_W    = DEN_W + QBITS;

    localparam int S_TDATA_W = ((6 * DATA_W + WGT_W + 7) / 8) * 8;
    localparam int M_TDATA_W = 4 * DATA_W;

    localparam logic [WGT_W-1:0] WGT_ONE = WGT_W'(1) << (WGT_W - 1);

    localparam logic [DATA_W-1:0] SAT_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] SAT_MIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [2:0] {
        OP_MAG   = 3'd0,
        OP_NORM  = 3'd1,
        OP_COS   = 3'd2,
        OP_CROSS = 3'd3,
        OP_LERP  = 3'd4
    } op_t;

    typedef logic [DATA_W-1:0] word_t;

    // Side data carried alongside the square-root pipeline.
    typedef struct packed {
        logic [2:0]              op;
        word_t [LANES-1:0]       a;
        word_t [LANES-1:0]       vec;
        logic [DOT_W-1:0]        dot;
    } sq_side_t;

    // Side data carried alongside the divider pipeline.
    typedef struct packed {
        logic [2:0]              op;
        logic                    zero_a;
        logic                    zero_b;
        word_t                   mag;
        word_t [LANES-1:0]       vec;
        logic [LANES-1:0]        neg;
    } dv_side_t;

    // Clamp a signed 64-bit value into the signed data word range.
    function automatic word_t sat_word(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = {{(64-DATA_W){1'b0}}, SAT_MAX};
        lo = {{(64-DATA_W){1'b1}}, SAT_MIN};
        if (v > hi) begin
            return SAT_MAX;
        end else if (v < lo) begin
            return SAT_MIN;
        end
        return v[DATA_W-1:0];
    endfunction

    // Apply sign to an unsigned quotient and saturate.
    function automatic word_t sat_quot(input logic [QBITS-1:0] q, input logic ovf,
                                       input logic neg);
        logic [QBITS-1:0] nq;
        nq = ~q + QBITS'(1);
        if (neg) begin
            if (ovf || (q > {1'b0, SAT_MIN})) begin
                return SAT_MIN;
            end
            return nq[DATA_W-1:0];
        end
        if (ovf || (q > {1'b0, SAT_MAX})) begin
            return SAT_MAX;
        end
        return q[DATA_W-1:0];
    endfunction

endpackage

// ===== src/vgu_mul.sv =====
// ----------------------------------------------------------------------
// Vector geometry unit product stages
// Two stages: all products, then sums of squares, dot, cross and lerp.
// ----------------------------------------------------------------------
module vgu_mul (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              adv,
    input  logic                              in_valid,
    input  logic [2:0]                        in_op,
    input  vgu_pkg::word_t [vgu_pkg::LANES-1:0] in_a,
    input  vgu_pkg::word_t [vgu_pkg::LANES-1:0] in_b,
    input  logic [vgu_pkg::WGT_W-1:0]         in_w,
    input  logic [vgu_pkg::WGT_W-1:0]         in_wb,
    output logic                              out_valid,
    output logic [vgu_pkg::SUM_W-1:0]         out_sum_a,
    output logic [vgu_pkg::SUM_W-1:0]         out_sum_b,
    output vgu_pkg::sq_side_t                 out_side
);
    import vgu_pkg::*;

    localparam int NPROD = 2 * LANES;

    logic signed [DATA_W:0]   opx [NPROD];
    logic signed [DATA_W:0]   opy [NPROD];
    logic signed [DATA_W:0]   ax  [LANES];
    logic signed [DATA_W:0]   bx  [LANES];
    logic signed [DATA_W:0]   wx;
    logic signed [DATA_W:0]   wbx;

    logic                     v1_reg;
    logic [2:0]               op1_reg;
    word_t [LANES-1:0]        a1_reg;
    logic [PROD_W-1:0]        sqa_reg [LANES];
    logic [PROD_W-1:0]        sqb_reg [LANES];
    logic signed [PROD_W-1:0] pg_reg  [NPROD];

    logic                     v2_reg;
    logic [SUM_W-1:0]         sum_a_reg;
    logic [SUM_W-1:0]         sum_b_reg;
    sq_side_t                 side2_reg;
    sq_side_t                 side2_next;

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            ax[i] = {in_a[i][DATA_W-1], in_a[i]};
            bx[i] = {in_b[i][DATA_W-1], in_b[i]};
        end
        wx  = {{(DATA_W+1-WGT_W){1'b0}}, in_w};
        wbx = {{(DATA_W+1-WGT_W){1'b0}}, in_wb};
        for (int k = 0; k < NPROD; k++) begin
            opx[k] = '0;
            opy[k] = '0;
        end
        unique case (in_op)
            OP_COS: begin
                for (int i = 0; i < LANES; i++) begin
                    opx[i] = ax[i];
                    opy[i] = bx[i];
                end
            end
            OP_CROSS: begin
                opx[0] = ax[1]; opy[0] = bx[2];
                opx[1] = bx[1]; opy[1] = ax[2];
                opx[2] = ax[2]; opy[2] = bx[0];
                opx[3] = bx[2]; opy[3] = ax[0];
                opx[4] = ax[0]; opy[4] = bx[1];
                opx[5] = bx[0]; opy[5] = ax[1];
            end
            OP_LERP: begin
                for (int i = 0; i < LANES; i++) begin
                    opx[2*i]   = ax[i]; opy[2*i]   = wx;
                    opx[2*i+1] = bx[i]; opy[2*i+1] = wbx;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            op1_reg <= in_op;
            a1_reg  <= in_a;
            for (int i = 0; i < LANES; i++) begin
                sqa_reg[i] <= PROD_W'($signed(in_a[i]) * $signed(in_a[i]));
                sqb_reg[i] <= PROD_W'($signed(in_b[i]) * $signed(in_b[i]));
            end
            for (int k = 0; k < NPROD; k++) begin
                pg_reg[k] <= PROD_W'(opx[k] * opy[k]);
            end
        end
    end

    always_comb begin
        logic signed [PROD_W:0] d;
        logic signed [PROD_W:0] sh;
        side2_next.op  = op1_reg;
        side2_next.a   = a1_reg;
        side2_next.dot = DOT_W'(pg_reg[0]) + DOT_W'(pg_reg[1]) + DOT_W'(pg_reg[2]);
        for (int i = 0; i < LANES; i++) begin
            if (op1_reg == OP_CROSS) begin
                d  = (PROD_W+1)'(pg_reg[2*i]) - (PROD_W+1)'(pg_reg[2*i+1]);
                sh = d >>> FRAC_BITS;
                side2_next.vec[i] = sat_word(64'(sh));
            end else if (op1_reg == OP_LERP) begin
                d  = (PROD_W+1)'(pg_reg[2*i]) + (PROD_W+1)'(pg_reg[2*i+1]);
                sh = d >>> (WGT_W - 1);
                side2_next.vec[i] = sat_word(64'(sh));
            end else begin
                d  = '0;
                sh = '0;
                side2_next.vec[i] = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sum_a_reg <= sqa_reg[0] + sqa_reg[1] + sqa_reg[2];
            sum_b_reg <= sqb_reg[0] + sqb_reg[1] + sqb_reg[2];
            side2_reg <= side2_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_sum_a = sum_a_reg;
    assign out_sum_b = sum_b_reg;
    assign out_side  = side2_reg;

endmodule

// ===== src/vgu_sqrt.sv =====
// ----------------------------------------------------------------------
// Vector geometry unit square root
// Two integer square roots, one result bit per pipeline stage.
// ----------------------------------------------------------------------
module vgu_sqrt (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        adv,
    input  logic                        in_valid,
    input  logic [vgu_pkg::SUM_W-1:0]   in_sum_a,
    input  logic [vgu_pkg::SUM_W-1:0]   in_sum_b,
    input  vgu_pkg::sq_side_t           in_side,
    output logic                        out_valid,
    output logic [vgu_pkg::ROOT_W-1:0]  out_root_a,
    output logic [vgu_pkg::ROOT_W-1:0]  out_root_b,
    output vgu_pkg::sq_side_t           out_side
);
    import vgu_pkg::*;

    logic                valid_reg  [ROOT_W];
    logic [SQ_REM_W-1:0] rem_a_reg  [ROOT_W];
    logic [SQ_REM_W-1:0] rem_b_reg  [ROOT_W];
    logic [ROOT_W-1:0]   root_a_reg [ROOT_W];
    logic [ROOT_W-1:0]   root_b_reg [ROOT_W];
    sq_side_t            side_reg   [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        localparam int BIT = ROOT_W - 1 - k;
        logic                v_in;
        logic [SQ_REM_W-1:0] rem_a_in;
        logic [SQ_REM_W-1:0] rem_b_in;
        logic [ROOT_W-1:0]   root_a_in;
        logic [ROOT_W-1:0]   root_b_in;
        sq_side_t            side_in;
        logic [SQ_REM_W-1:0] trial_a;
        logic [SQ_REM_W-1:0] trial_b;

        if (k == 0) begin : g_first
            assign v_in      = in_valid;
            assign rem_a_in  = SQ_REM_W'(in_sum_a);
            assign rem_b_in  = SQ_REM_W'(in_sum_b);
            assign root_a_in = '0;
            assign root_b_in = '0;
            assign side_in   = in_side;
        end else begin : g_next
            assign v_in      = valid_reg[k-1];
            assign rem_a_in  = rem_a_reg[k-1];
            assign rem_b_in  = rem_b_reg[k-1];
            assign root_a_in = root_a_reg[k-1];
            assign root_b_in = root_b_reg[k-1];
            assign side_in   = side_reg[k-1];
        end

        // (root + 2^BIT)^2 - root^2 = root * 2^(BIT+1) + 2^(2*BIT)
        assign trial_a = (SQ_REM_W'(root_a_in) << (BIT + 1)) + (SQ_REM_W'(1) << (2 * BIT));
        assign trial_b = (SQ_REM_W'(root_b_in) << (BIT + 1)) + (SQ_REM_W'(1) << (2 * BIT));

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (adv) begin
                valid_reg[k] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                side_reg[k] <= side_in;
                if (rem_a_in >= trial_a) begin
                    rem_a_reg[k]  <= rem_a_in - trial_a;
                    root_a_reg[k] <= root_a_in | (ROOT_W'(1) << BIT);
                end else begin
                    rem_a_reg[k]  <= rem_a_in;
                    root_a_reg[k] <= root_a_in;
                end
                if (rem_b_in >= trial_b) begin
                    rem_b_reg[k]  <= rem_b_in - trial_b;
                    root_b_reg[k] <= root_b_in | (ROOT_W'(1) << BIT);
                end else begin
                    rem_b_reg[k]  <= rem_b_in;
                    root_b_reg[k] <= root_b_in;
                end
            end
        end
    end

    assign out_valid  = valid_reg[ROOT_W-1];
    assign out_root_a = root_a_reg[ROOT_W-1];
    assign out_root_b = root_b_reg[ROOT_W-1];
    assign out_side   = side_reg[ROOT_W-1];

endmodule

// ===== src/vgu_div.sv =====
// ----------------------------------------------------------------------
// Vector geometry unit divider
// Operand setup, overflow check and three restoring divider lanes.
// ----------------------------------------------------------------------
module vgu_div (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        adv,
    input  logic                        in_valid,
    input  logic [vgu_pkg::ROOT_W-1:0]  in_root_a,
    input  logic [vgu_pkg::ROOT_W-1:0]  in_root_b,
    input  vgu_pkg::sq_side_t           in_side,
    output logic                        out_valid,
    output logic [vgu_pkg::QBITS-1:0]   out_q   [vgu_pkg::LANES],
    output logic                        out_ovf [vgu_pkg::LANES],
    output vgu_pkg::dv_side_t           out_side
);
    import vgu_pkg::*;

    localparam int NST = QBITS + 1;

    // Operand setup stage.
    logic              vp_reg;
    logic [NUM_W-1:0]  np_reg [LANES];
    logic [DEN_W-1:0]  dp_reg [LANES];
    dv_side_t          sp_reg;
    logic [NUM_W-1:0]  np_next [LANES];
    logic [DEN_W-1:0]  dp_next [LANES];
    dv_side_t          sp_next;

    always_comb begin
        logic [DOT_W-1:0]  dot_abs;
        logic [DATA_W:0]   a_abs;
        logic              dneg;
        dneg    = in_side.dot[DOT_W-1];
        dot_abs = dneg ? (~in_side.dot + DOT_W'(1)) : in_side.dot;
        a_abs   = '0;
        sp_next.op     = in_side.op;
        sp_next.zero_a = (in_root_a == '0);
        sp_next.zero_b = (in_root_b == '0);
        sp_next.mag    = in_root_a[ROOT_W-1] ? SAT_MAX : in_root_a;
        sp_next.vec    = in_side.vec;
        for (int i = 0; i < LANES; i++) begin
            a_abs          = in_side.a[i][DATA_W-1] ? (~{1'b1, in_side.a[i]} + (DATA_W+1)'(1))
                                                    : {1'b0, in_side.a[i]};
            np_next[i]     = NUM_W'(a_abs) << FRAC_BITS;
            dp_next[i]     = DEN_W'(in_root_a);
            sp_next.neg[i] = in_side.a[i][DATA_W-1];
        end
        if (in_side.op == OP_COS) begin
            np_next[0]     = NUM_W'(dot_abs[DEN_W-1:0]) << FRAC_BITS;
            dp_next[0]     = DEN_W'(in_root_a) * DEN_W'(in_root_b);
            sp_next.neg[0] = dneg;
        end
    end

    // Divider stage arrays: index 0 is the overflow check, then one quotient bit each.
    logic              v_reg   [NST];
    logic [NUM_W-1:0]  rem_reg [NST][LANES];
    logic [DEN_W-1:0]  den_reg [NST][LANES];
    logic [QBITS-1:0]  q_reg   [NST][LANES];
    logic              ovf_reg [NST][LANES];
    dv_side_t          side_reg [NST];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vp_reg <= 1'b0;
        end else if (adv) begin
            vp_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            np_reg <= np_next;
            dp_reg <= dp_next;
            sp_reg <= sp_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (adv) begin
            v_reg[0] <= vp_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            side_reg[0] <= sp_reg;
            for (int i = 0; i < LANES; i++) begin
                rem_reg[0][i] <= np_reg[i];
                den_reg[0][i] <= dp_reg[i];
                q_reg[0][i]   <= '0;
                ovf_reg[0][i] <= (CMP_W'(np_reg[i]) >= (CMP_W'(dp_reg[i]) << QBITS));
            end
        end
    end

    for (genvar k = 1; k < NST; k++) begin : g_stage
        localparam int BIT = QBITS - k;
        logic [CMP_W-1:0] sub [LANES];

        always_comb begin
            for (int i = 0; i < LANES; i++) begin
                sub[i] = CMP_W'(den_reg[k-1][i]) << BIT;
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[k] <= 1'b0;
            end else if (adv) begin
                v_reg[k] <= v_reg[k-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                side_reg[k] <= side_reg[k-1];
                for (int i = 0; i < LANES; i++) begin
                    den_reg[k][i] <= den_reg[k-1][i];
                    ovf_reg[k][i] <= ovf_reg[k-1][i];
                    if (CMP_W'(rem_reg[k-1][i]) >= sub[i]) begin
                        rem_reg[k][i] <= rem_reg[k-1][i] - sub[i][NUM_W-1:0];
                        q_reg[k][i]   <= q_reg[k-1][i] | (QBITS'(1) << BIT);
                    end else begin
                        rem_reg[k][i] <= rem_reg[k-1][i];
                        q_reg[k][i]   <= q_reg[k-1][i];
                    end
                end
            end
        end
    end

    assign out_valid = v_reg[NST-1];
    assign out_side  = side_reg[NST-1];
    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            out_q[i]   = q_reg[NST-1][i];
            out_ovf[i] = ovf_reg[NST-1][i];
        end
    end

endmodule

// ===== src/vector3_geometry_unit_core.sv =====
// ----------------------------------------------------------------------
// Vector geometry unit core
// Stages: input register, product stages, 32-stage square root, 35-stage
// divider, output register. Throughput: one beat per cycle unless stalled.
// Reset: synchronous, active low; clears all valid bits, no clearing pass.
// ----------------------------------------------------------------------
module vector3_geometry_unit_core (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, weight from bit 0 up, zero padded
    input  logic [vgu_pkg::S_TDATA_W-1:0]   s_tdata,
    // operation
    input  logic [2:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // res_x, res_y, res_z, scalar from bit 0 up
    output logic [vgu_pkg::M_TDATA_W-1:0]   m_tdata,
    // error
    output logic                            m_tuser
);
    import vgu_pkg::*;

    // The whole pipeline advances whenever the output register is free or
    // being drained. Each stage keeps its own valid bit, so bubbles are
    // carried without loss and a stall freezes every stage in place.
    logic adv;

    logic                 in_v_reg;
    logic [2:0]           in_op_reg;
    word_t [LANES-1:0]    in_a_reg;
    word_t [LANES-1:0]    in_b_reg;
    logic [WGT_W-1:0]     in_w_reg;
    logic [WGT_W-1:0]     in_wb_reg;
    logic [WGT_W-1:0]     w_raw;
    logic [WGT_W-1:0]     w_clamp;

    logic                 mul_valid;
    logic [SUM_W-1:0]     mul_sum_a;
    logic [SUM_W-1:0]     mul_sum_b;
    sq_side_t             mul_side;

    logic                 sq_valid;
    logic [ROOT_W-1:0]    sq_root_a;
    logic [ROOT_W-1:0]    sq_root_b;
    sq_side_t             sq_side;

    logic                 dv_valid;
    logic [QBITS-1:0]     dv_q   [LANES];
    logic                 dv_ovf [LANES];
    dv_side_t             dv_side;

    logic                 m_tvalid_reg;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [M_TDATA_W-1:0] m_tdata_next;
    logic                 m_tuser_reg;
    logic                 m_tuser_next;

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;

    // Weights above one are clamped to one before the blend.
    assign w_raw   = s_tdata[6*DATA_W +: WGT_W];
    assign w_clamp = (w_raw > WGT_ONE) ? WGT_ONE : w_raw;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg <= 1'b0;
        end else if (adv) begin
            in_v_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            in_op_reg <= s_tuser;
            for (int i = 0; i < LANES; i++) begin
                in_a_reg[i] <= s_tdata[i*DATA_W +: DATA_W];
                in_b_reg[i] <= s_tdata[(i+LANES)*DATA_W +: DATA_W];
            end
            in_w_reg  <= w_clamp;
            in_wb_reg <= WGT_ONE - w_clamp;
        end
    end

    vgu_mul u_mul (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (in_v_reg),
        .in_op     (in_op_reg),
        .in_a      (in_a_reg),
        .in_b      (in_b_reg),
        .in_w      (in_w_reg),
        .in_wb     (in_wb_reg),
        .out_valid (mul_valid),
        .out_sum_a (mul_sum_a),
        .out_sum_b (mul_sum_b),
        .out_side  (mul_side)
    );

    vgu_sqrt u_sqrt (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .adv        (adv),
        .in_valid   (mul_valid),
        .in_sum_a   (mul_sum_a),
        .in_sum_b   (mul_sum_b),
        .in_side    (mul_side),
        .out_valid  (sq_valid),
        .out_root_a (sq_root_a),
        .out_root_b (sq_root_b),
        .out_side   (sq_side)
    );

    vgu_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (sq_valid),
        .in_root_a (sq_root_a),
        .in_root_b (sq_root_b),
        .in_side   (sq_side),
        .out_valid (dv_valid),
        .out_q     (dv_q),
        .out_ovf   (dv_ovf),
        .out_side  (dv_side)
    );

    // Final selection per operation. Normalize of a zero vector gives zeros,
    // and cosine with a zero-length operand raises the error flag instead.
    always_comb begin
        m_tdata_next = '0;
        m_tuser_next = 1'b0;
        unique case (dv_side.op)
            OP_MAG: begin
                m_tdata_next[3*DATA_W +: DATA_W] = dv_side.mag;
            end
            OP_NORM: begin
                if (!dv_side.zero_a) begin
                    for (int i = 0; i < LANES; i++) begin
                        m_tdata_next[i*DATA_W +: DATA_W] =
                            sat_quot(dv_q[i], dv_ovf[i], dv_side.neg[i]);
                    end
                end
            end
            OP_COS: begin
                if (dv_side.zero_a || dv_side.zero_b) begin
                    m_tuser_next = 1'b1;
                end else begin
                    m_tdata_next[3*DATA_W +: DATA_W] =
                        sat_quot(dv_q[0], dv_ovf[0], dv_side.neg[0]);
                end
            end
            OP_CROSS, OP_LERP: begin
                for (int i = 0; i < LANES; i++) begin
                    m_tdata_next[i*DATA_W +: DATA_W] = dv_side.vec[i];
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // An error beat carries a zero scalar.
    a_err_scalar: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[4*DATA_W-1:3*DATA_W] == '0))
        else $error("error beat with nonzero scalar");

    // An error beat carries a zero vector.
    a_err_vec: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> (m_tdata[3*DATA_W-1:0] == '0))
        else $error("error beat with nonzero vector");

    // No result is presented right after reset.
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

// ===== tb/tb_vector3_geometry_unit_core.sv =====
// ----------------------------------------------------------------------
// Vector geometry unit core testbench
// Streams directed and random vector beats through the core under several
// idle and stall patterns and checks every result beat against an exact
// wide-integer prediction of magnitude, normalize, cosine, cross and lerp.
// ----------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_vector3_geometry_unit_core;

    import vgu_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int DRAIN_CYCLES   = 100;

    typedef struct {
        logic [2:0]         op;
        logic signed [31:0] a [3];
        logic signed [31:0] b [3];
        logic [16:0]        weight;
    } vec_item_t;

    typedef struct {
        logic [31:0] res [3];
        logic [31:0] scalar;
        logic        error;
    } vec_result_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    // a_x, a_y, a_z, b_x, b_y, b_z, weight from bit 0 up, zero padded
    logic [S_TDATA_W-1:0]   s_tdata;
    // operation
    logic [2:0]             s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    // res_x, res_y, res_z, scalar from bit 0 up
    logic [M_TDATA_W-1:0]   m_tdata;
    // error
    logic                   m_tuser;

    vector3_geometry_unit_core i_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    vec_item_t   pending_items [$];
    vec_result_t expected_results [$];
    int          fail_count;
    int          beats_in;
    int          beats_out;
    int          op_seen [8];
    int          idle_pct;
    int          stall_pct;
    bit          hold_off;
    bit          stimulus_done;
    int          quiet_cycles;

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Clamp an exact signed value to the 32-bit signed word range.
    function automatic logic [31:0] clamp_word(input logic signed [159:0] v);
        if (v > 160'sd2147483647) begin
            return 32'h7fff_ffff;
        end
        if (v < -160'sd2147483648) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction

    // Floor square root of a nonnegative value, bit by bit.
    function automatic logic [63:0] floor_root(input logic [159:0] s);
        logic [63:0]  root;
        logic [63:0]  trial;
        root = '0;
        for (int i = 63; i >= 0; i--) begin
            trial = root | (64'd1 << i);
            if ({96'd0, trial} * {96'd0, trial} <= s) begin
                root = trial;
            end
        end
        return root;
    endfunction

    function automatic logic [159:0] norm_sq(input logic signed [31:0] v [3]);
        logic signed [159:0] acc;
        acc = 0;
        for (int i = 0; i < 3; i++) begin
            acc += 160'(v[i]) * 160'(v[i]);
        end
        return acc;
    endfunction

    // Signed quotient truncated toward zero (SystemVerilog division does this).
    function automatic logic [31:0] trunc_quot(input logic signed [159:0] n,
                                               input logic signed [159:0] d);
        return clamp_word(n / d);
    endfunction

    function automatic vec_result_t predict_geometry(input vec_item_t it);
        vec_result_t         r;
        logic [63:0]         mag_a;
        logic [63:0]         mag_b;
        logic signed [159:0] dot;
        logic signed [159:0] c [3];
        logic signed [159:0] wa;
        logic signed [159:0] wb;
        r.res = '{0, 0, 0};
        r.scalar = '0;
        r.error = 1'b0;
        mag_a = floor_root(norm_sq(it.a));
        mag_b = floor_root(norm_sq(it.b));
        case (it.op)
            OP_MAG: begin
                r.scalar = clamp_word($signed({96'd0, mag_a}));
            end
            OP_NORM: begin
                if (mag_a != 0) begin
                    for (int i = 0; i < 3; i++) begin
                        r.res[i] = trunc_quot(160'(it.a[i]) <<< FRAC_BITS,
                                              $signed({96'd0, mag_a}));
                    end
                end
            end
            OP_COS: begin
                if (mag_a == 0 || mag_b == 0) begin
                    r.error = 1'b1;
                end else begin
                    dot = 0;
                    for (int i = 0; i < 3; i++) begin
                        dot += 160'(it.a[i]) * 160'(it.b[i]);
                    end
                    r.scalar = trunc_quot(dot <<< FRAC_BITS,
                                          $signed({96'd0, mag_a}) * $signed({96'd0, mag_b}));
                end
            end
            OP_CROSS: begin
                c[0] = 160'(it.a[1]) * 160'(it.b[2]) - 160'(it.b[1]) * 160'(it.a[2]);
                c[1] = 160'(it.a[2]) * 160'(it.b[0]) - 160'(it.b[2]) * 160'(it.a[0]);
                c[2] = 160'(it.a[0]) * 160'(it.b[1]) - 160'(it.b[0]) * 160'(it.a[1]);
                for (int i = 0; i < 3; i++) begin
                    r.res[i] = clamp_word(c[i] >>> FRAC_BITS);
                end
            end
            OP_LERP: begin
                // Weights above one are clamped to exactly one.
                wa = (it.weight > 17'd65536) ? 160'sd65536 : $signed({143'd0, it.weight});
                wb = 160'sd65536 - wa;
                for (int i = 0; i < 3; i++) begin
                    r.res[i] = clamp_word((160'(it.a[i]) * wa + 160'(it.b[i]) * wb) >>> 16);
                end
            end
            default: begin
                // Unknown codes return all zeros.
            end
        endcase
        return r;
    endfunction

    function automatic logic signed [31:0] rand_comp();
        case ($urandom_range(0, 5))
            0: return 32'sh7fff_ffff - $urandom_range(0, 2);
            1: return 32'sh8000_0000 + $urandom_range(0, 2);
            2: return $urandom_range(0, 8) - 4;
            3: return $signed($urandom_range(0, 32'h0003_ffff)) - 32'sh0002_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic vec_item_t random_item();
        vec_item_t it;
        it.op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                               : 3'($urandom_range(0, 4));
        for (int i = 0; i < 3; i++) begin
            it.a[i] = rand_comp();
            it.b[i] = rand_comp();
        end
        // Zero vectors exercise the cosine error and normalize special case.
        if ($urandom_range(0, 9) == 0) begin
            it.a = '{0, 0, 0};
        end
        if ($urandom_range(0, 9) == 0) begin
            it.b = '{0, 0, 0};
        end
        case ($urandom_range(0, 3))
            0: it.weight = 17'($urandom_range(0, 1) * 65536);
            1: it.weight = 17'($urandom_range(65537, 131071));
            default: it.weight = 17'($urandom_range(0, 65536));
        endcase
        return it;
    endfunction

    function automatic vec_item_t make_item(input logic [2:0] op,
                                            input logic signed [31:0] av,
                                            input logic signed [31:0] bv,
                                            input logic [16:0] w);
        vec_item_t it;
        it.op = op;
        it.a = '{av, -av, av};
        it.b = '{bv, bv, -bv};
        it.weight = w;
        return it;
    endfunction

    // Sender: a new beat is taken from the queue when the bus is free.
    always @(posedge aclk) begin
        vec_item_t it;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (pending_items.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                it = pending_items.pop_front();
                s_tvalid <= 1'b1;
                s_tuser  <= it.op;
                s_tdata  <= S_TDATA_W'({it.weight, it.b[2], it.b[1], it.b[0],
                                        it.a[2], it.a[1], it.a[0]});
                expected_results.push_back(predict_geometry(it));
                op_seen[it.op]++;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
        if (aresetn && s_tvalid && s_tready) begin
            beats_in++;
        end
    end

    // Receiver: ready is drawn each cycle; results are checked on acceptance.
    always @(posedge aclk) begin
        vec_result_t exp_r;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            m_tready <= !hold_off && ($urandom_range(0, 99) >= stall_pct);
            if (m_tvalid && m_tready) begin
                beats_out++;
                if (expected_results.size() == 0) begin
                    $error("result beat with no expectation waiting");
                    fail_count++;
                end else begin
                    exp_r = expected_results.pop_front();
                    for (int i = 0; i < 3; i++) begin
                        if (m_tdata[32*i +: 32] !== exp_r.res[i]) begin
                            $error("res[%0d]: expected %h, got %h", i, exp_r.res[i],
                                   m_tdata[32*i +: 32]);
                            fail_count++;
                        end
                    end
                    if (m_tdata[96 +: 32] !== exp_r.scalar) begin
                        $error("scalar: expected %h, got %h", exp_r.scalar, m_tdata[96 +: 32]);
                        fail_count++;
                    end
                    if (m_tuser !== exp_r.error) begin
                        $error("error: expected %b, got %b", exp_r.error, m_tuser);
                        fail_count++;
                    end
                end
            end
        end
    end

    // Watchdog on cycles without any accepted beat.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (aresetn && !stimulus_done) begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("vector3_geometry_unit_core regression: fail");
                $finish;
            end
        end
    end

    // Long receiver hold-off while the sender keeps offering beats.
    initial begin
        hold_off = 1'b0;
        wait (beats_in > 300);
        @(posedge aclk);
        hold_off <= 1'b1;
        repeat (400) @(posedge aclk);
        hold_off <= 1'b0;
    end

    task automatic run_phase(input int n, input int idle, input int stall);
        idle_pct = idle;
        stall_pct = stall;
        for (int k = 0; k < n; k++) begin
            pending_items.push_back(random_item());
        end
        wait (pending_items.size() == 0);
    endtask

    initial begin
        logic signed [31:0] edge_vals [6];
        fail_count = 0;
        beats_in = 0;
        beats_out = 0;
        quiet_cycles = 0;
        stimulus_done = 1'b0;
        idle_pct = 0;
        stall_pct = 0;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        m_tready = 1'b0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed beats: field extremes, every operation, zero vectors,
        // weights at and above one, and unknown operation codes.
        edge_vals = '{32'sh7fff_ffff, 32'sh8000_0000, 0, 32'sh0001_0000, -1, 32'sh0000_0001};
        for (int op = 0; op < 5; op++) begin
            for (int e = 0; e < 4; e++) begin
                pending_items.push_back(make_item(3'(op), edge_vals[e], edge_vals[5 - e],
                                                  (e == 0) ? 17'h1ffff : 17'(e * 21845)));
            end
        end
        pending_items.push_back(make_item(3'd5, 32'sh7fff_ffff, -1, 17'd0));
        pending_items.push_back(make_item(3'd7, -1, -1, 17'h1ffff));
        pending_items.push_back(make_item(OP_COS, 0, 32'sh0001_0000, 17'd65536));
        wait (pending_items.size() == 0);

        // Pause the sender until every outstanding result has arrived.
        wait (expected_results.size() == 0);
        run_phase(400, 0, 0);
        run_phase(350, 71, 0);
        run_phase(350, 0, 71);
        run_phase(300, 29, 29);

        wait (expected_results.size() == 0);
        stimulus_done = 1'b1;
        repeat (DRAIN_CYCLES) @(posedge aclk);
        $display("Sent %0d beats, checked %0d results.", beats_in, beats_out);
        $display("Ops: mag %0d norm %0d cos %0d cross %0d lerp %0d unknown %0d.",
                 op_seen[0], op_seen[1], op_seen[2], op_seen[3], op_seen[4],
                 op_seen[5] + op_seen[6] + op_seen[7]);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("vector3_geometry_unit_core regression: pass");
        end else begin
            $display("vector3_geometry_unit_core regression: fail");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
src/vgu_pkg.sv
src/vgu_mul.sv
src/vgu_sqrt.sv
src/vgu_div.sv
src/vector3_geometry_unit_core.sv
tb/tb_vector3_geometry_unit_core.sv
